/* hdl/ccfs_pkg.sv */
// shared constants, cordic arctangent table and saturation helper for the chase camera block
`default_nettype none
package ccfs_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX       = 24;

  localparam logic [15:0]        FOLLOW_DIST_RST = 16'd2048;
  localparam logic signed [15:0] FOLLOW_HGT_RST  = 16'sd768;
  localparam logic signed [15:0] LOOK_HGT_RST    = 16'sd384;
  localparam logic [15:0]        SMOOTH_RATE_RST = 16'd1280;

  localparam logic signed [31:0] POS_X_RST = 32'sd0;
  localparam logic signed [31:0] POS_Y_RST = 32'sd196608;
  localparam logic signed [31:0] POS_Z_RST = -32'sd524288;

  // cos(0.15) times the cordic gain, q2.30
  localparam logic signed [33:0] CORDIC_INIT = 34'sd644711246;

  localparam logic [7:0] REG_FOLLOW_DIST = 8'd0;
  localparam logic [7:0] REG_FOLLOW_HGT  = 8'd1;
  localparam logic [7:0] REG_LOOK_HGT    = 8'd2;
  localparam logic [7:0] REG_SMOOTH_RATE = 8'd3;

  localparam logic [24:0] T_ONE    = 25'd16777216;
  localparam logic [14:0] FWD_ONE  = 15'd16384;
  localparam logic [3:0]  DIV_LAST = 4'd14;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/chase_camera_follow_step.sv */
// chase camera follow step: sequencer around one shared multiplier, cordic and divider
// steps in order: cordic rotation, offset and time-step multiplies, position update,
//   look vector, squares, square root, three divides, output load; degenerate words skip
//   the squares, root and divide; the next word is taken only after the last one leaves
//   the sequencer, later while an unread output blocks
// a finished word waits in the output register while the next word is taken
// rst (synchronous) restores the default settings and the start camera position
`default_nettype none
module chase_camera_follow_step
  import ccfs_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // target_x[31:0], target_y[63:32], target_z[95:64], target_yaw[111:96], time_step[127:112]
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // cam_x[31:0], cam_y[63:32], cam_z[95:64], fwd_x[111:96], fwd_y[127:112], fwd_z[143:128]
  output logic [143:0]      m_tdata,
  // degenerate[0]
  output logic              m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int CIW = $clog2(CORDIC_STEPS);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_CORD = 17'h00002,
    S_OFX  = 17'h00004,
    S_OFZ  = 17'h00008,
    S_TM   = 17'h00010,
    S_TS   = 17'h00020,
    S_PM   = 17'h00040,
    S_PU   = 17'h00080,
    S_LV   = 17'h00100,
    S_SH   = 17'h00200,
    S_SQ   = 17'h00400,
    S_SA   = 17'h00800,
    S_RT   = 17'h01000,
    S_DI   = 17'h02000,
    S_DV   = 17'h04000,
    S_DF   = 17'h08000,
    S_DONE = 17'h10000
  } state_t;

  state_t state;

  logic [15:0]        follow_distance, smooth_rate;
  logic signed [15:0] follow_height, look_height;

  logic signed [31:0] tx, ty, tz;
  logic [15:0]        dt;
  logic signed [31:0] pos [3];
  logic signed [31:0] des [3];
  logic signed [32:0] vec [3];
  logic [31:0]        mg  [3];
  logic               sgn [3];
  logic signed [15:0] fwd [3];
  logic               degen;

  logic signed [33:0] ang, cx, cy;
  logic               flip;
  logic [CIW-1:0]     cord_i;
  logic [1:0]         k;
  logic [24:0]        tq;
  logic [63:0]        sum, rv, rr, bitreg;
  logic [31:0]        len;
  logic [46:0]        num, dsh;
  logic [14:0]        q;
  logic [3:0]         dcnt;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_OFX: begin
        ma = flip ? cy[32:0] : -cy[32:0];
        mb = {17'b0, follow_distance};
      end
      S_OFZ: begin
        ma = flip ? -cx[32:0] : cx[32:0];
        mb = {17'b0, follow_distance};
      end
      S_TM: begin
        ma = {17'b0, smooth_rate};
        mb = {17'b0, dt};
      end
      S_PM: begin
        ma = 33'(des[k]) - 33'(pos[k]);
        mb = {8'b0, tq};
      end
      S_SQ: begin
        ma = {1'b0, mg[k]};
        mb = {1'b0, mg[k]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  logic signed [31:0] a32;
  logic signed [33:0] cx_sh, cy_sh, atan_v;
  logic signed [35:0] off36, step36;
  logic signed [31:0] look_y;
  logic               big;
  logic signed [33:0] vs [3];
  logic [63:0]        sum_nx, rt_try, rr_nx;
  logic               rt_ge;
  logic [14:0]        qc;

  always_comb begin
    a32    = s_tdata[111:96] << 16;
    cx_sh  = cx >>> cord_i;
    cy_sh  = cy >>> cord_i;
    atan_v = 34'(atan_lut(5'(cord_i)));
    off36  = 36'(tx) + 36'((prod + 66'sd2097152) >>> 22);
    step36 = 36'(pos[k]) + 36'((prod + 66'sd8388608) >>> 24);
    look_y = sat32(36'(ty) + 36'($signed({look_height, 8'b0})));
    big    = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (vec[j] >= 33'sd2147483648 || vec[j] <= -33'sd2147483648) big = 1'b1;
    end
    for (int j = 0; j < 3; j++) begin
      vs[j] = big ? (34'(vec[j]) >>> 1) : 34'(vec[j]);
    end
    sum_nx = sum + prod[63:0];
    rt_try = rr + bitreg;
    rt_ge  = (rv >= rt_try);
    rr_nx  = rt_ge ? ((rr >> 1) + bitreg) : (rr >> 1);
    qc     = (q > FWD_ONE) ? FWD_ONE : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      follow_distance <= FOLLOW_DIST_RST;
      follow_height   <= FOLLOW_HGT_RST;
      look_height     <= LOOK_HGT_RST;
      smooth_rate     <= SMOOTH_RATE_RST;
      pos[0]          <= POS_X_RST;
      pos[1]          <= POS_Y_RST;
      pos[2]          <= POS_Z_RST;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FOLLOW_DIST: follow_distance <= cfg_data;
          REG_FOLLOW_HGT:  follow_height   <= cfg_data;
          REG_LOOK_HGT:    look_height     <= cfg_data;
          REG_SMOOTH_RATE: smooth_rate     <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            tx     <= s_tdata[31:0];
            ty     <= s_tdata[63:32];
            tz     <= s_tdata[95:64];
            dt     <= s_tdata[127:112];
            cx     <= CORDIC_INIT;
            cy     <= '0;
            cord_i <= '0;
            // fold into a quarter turn either side, undo by negating later
            if (a32 > 32'sd1073741824) begin
              ang  <= 34'(a32) - 34'sd2147483648;
              flip <= 1'b1;
            end else if (a32 < -32'sd1073741824) begin
              ang  <= 34'(a32) + 34'sd2147483648;
              flip <= 1'b1;
            end else begin
              ang  <= 34'(a32);
              flip <= 1'b0;
            end
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (!ang[33]) begin
            cx  <= cx - cy_sh;
            cy  <= cy + cx_sh;
            ang <= ang - atan_v;
          end else begin
            cx  <= cx + cy_sh;
            cy  <= cy - cx_sh;
            ang <= ang + atan_v;
          end
          if (cord_i == CIW'(CORDIC_STEPS - 1)) state <= S_OFX;
          else cord_i <= cord_i + 1'b1;
        end
        S_OFX: state <= S_OFZ;
        S_OFZ: begin
          des[0] <= sat32(off36);
          state  <= S_TM;
        end
        S_TM: begin
          des[2] <= sat32(36'(tz) + 36'((prod + 66'sd2097152) >>> 22));
          des[1] <= sat32(36'(ty) + 36'($signed({follow_height, 8'b0})));
          state  <= S_TS;
        end
        S_TS: begin
          tq    <= (prod[32:0] >= 33'(T_ONE)) ? T_ONE : prod[24:0];
          k     <= 2'd0;
          state <= S_PM;
        end
        S_PM: state <= S_PU;
        S_PU: begin
          pos[k] <= sat32(step36);
          if (k == 2'd2) state <= S_LV;
          else begin
            k     <= k + 1'b1;
            state <= S_PM;
          end
        end
        S_LV: begin
          vec[0] <= 33'(tx) - 33'(pos[0]);
          vec[1] <= 33'(look_y) - 33'(pos[1]);
          vec[2] <= 33'(tz) - 33'(pos[2]);
          for (int j = 0; j < 3; j++) fwd[j] <= '0;
          degen <= (tx == pos[0]) && (look_y == pos[1]) && (tz == pos[2]);
          state <= ((tx == pos[0]) && (look_y == pos[1]) && (tz == pos[2])) ? S_DONE : S_SH;
        end
        S_SH: begin
          for (int j = 0; j < 3; j++) begin
            sgn[j] <= vs[j][33];
            mg[j]  <= vs[j][33] ? 32'(-vs[j]) : vs[j][31:0];
          end
          sum   <= '0;
          k     <= 2'd0;
          state <= S_SQ;
        end
        S_SQ: state <= S_SA;
        S_SA: begin
          sum <= sum_nx;
          if (k == 2'd2) begin
            rv     <= sum_nx;
            rr     <= '0;
            bitreg <= 64'd1 << 62;
            state  <= S_RT;
          end else begin
            k     <= k + 1'b1;
            state <= S_SQ;
          end
        end
        S_RT: begin
          if (rt_ge) rv <= rv - rt_try;
          rr     <= rr_nx;
          bitreg <= bitreg >> 2;
          if (bitreg == 64'd1) begin
            len   <= (rr_nx == 64'd0) ? 32'd1 : rr_nx[31:0];
            k     <= 2'd0;
            state <= S_DI;
          end
        end
        S_DI: begin
          num   <= {1'b0, mg[k], 14'b0} + 47'(len >> 1);
          dsh   <= {1'b0, len, 14'b0};
          q     <= '0;
          dcnt  <= DIV_LAST;
          state <= S_DV;
        end
        S_DV: begin
          if (num >= dsh) num <= num - dsh;
          q   <= {q[13:0], (num >= dsh)};
          dsh <= dsh >> 1;
          if (dcnt == 4'd0) state <= S_DF;
          else dcnt <= dcnt - 1'b1;
        end
        S_DF: begin
          fwd[k] <= sgn[k] ? -16'({1'b0, qc}) : 16'({1'b0, qc});
          if (k == 2'd2) state <= S_DONE;
          else begin
            k     <= k + 1'b1;
            state <= S_DI;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {fwd[2], fwd[1], fwd[0], pos[2], pos[1], pos[0]};
            m_tuser  <= degen;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_CORD))
    else $error("accepted word did not start the rotation");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready)) |=> (m_tvalid && state == S_IDLE))
    else $error("finished word not loaded into output register");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DF) |-> (q <= FWD_ONE))
    else $error("forward quotient exceeded unit length");

  a_cord_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORD) |-> (32'(cord_i) < CORDIC_STEPS))
    else $error("cordic step counter out of range");

endmodule
`default_nettype wire

/* test/tb_chase_camera_follow_step.sv */
// self-checking testbench for the chase camera follow step block
`default_nettype none
module tb_chase_camera_follow_step;
  import ccfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] tx, ty, tz;
    logic [15:0] yaw, dt;
  } target_t;

  typedef struct {
    logic [31:0] cx, cy, cz;
    logic [15:0] fx, fy, fz;
    logic        degen;
  } camera_t;

  localparam longint ATAN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [143:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 0, cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  chase_camera_follow_step DUT (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // predictor copy of settings and camera position
  longint dist_q, rate_q, fhgt_q, lhgt_q, px, py, pz;
  target_t pending_targets[$];
  camera_t expected_views[$];
  int errors = 0;
  longint cycles = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic apply_setting(input logic [7:0] idx, input logic [15:0] val);
    case (idx)
      REG_FOLLOW_DIST: dist_q = longint'(val);
      REG_FOLLOW_HGT:  fhgt_q = longint'($signed(val));
      REG_LOOK_HGT:    lhgt_q = longint'($signed(val));
      REG_SMOOTH_RATE: rate_q = longint'(val);
      default: ;
    endcase
  endtask

  function automatic camera_t follow_target(target_t it);
    camera_t r;
    longint tx, ty, tz, ang, cx, cy, nx, offx, offz, dx, dy, dz, t;
    longint v[3], m, len, q;
    longint unsigned sum;
    int s;
    bit flip;
    tx = longint'($signed(it.tx));
    ty = longint'($signed(it.ty));
    tz = longint'($signed(it.tz));
    ang = longint'($signed({it.yaw, 16'h0}));
    cx = 644711246;
    cy = 0;
    flip = 0;
    if (ang > 64'sd1073741824) begin
      ang -= 64'sd2147483648; flip = 1;
    end else if (ang < -64'sd1073741824) begin
      ang += 64'sd2147483648; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (ang >= 0) begin
        nx = cx - (cy >>> i); cy = cy + (cx >>> i); ang -= ATAN[i];
      end else begin
        nx = cx + (cy >>> i); cy = cy - (cx >>> i); ang += ATAN[i];
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    offx = floor_shift(dist_q * (-cy) + 2097152, 22);
    offz = floor_shift(dist_q * cx + 2097152, 22);
    dx = clamp32(tx + offx);
    dy = clamp32(ty + fhgt_q * 256);
    dz = clamp32(tz + offz);
    t = rate_q * longint'(it.dt);
    if (t >= 16777216) t = 16777216;
    px = clamp32(px + floor_shift((dx - px) * t + 8388608, 24));
    py = clamp32(py + floor_shift((dy - py) * t + 8388608, 24));
    pz = clamp32(pz + floor_shift((dz - pz) * t + 8388608, 24));
    v[0] = tx - px;
    v[1] = clamp32(ty + lhgt_q * 256) - py;
    v[2] = tz - pz;
    r.cx = px[31:0];
    r.cy = py[31:0];
    r.cz = pz[31:0];
    r.degen = (v[0] == 0 && v[1] == 0 && v[2] == 0);
    r.fx = 0; r.fy = 0; r.fz = 0;
    if (!r.degen) begin
      m = mag64(v[0]);
      if (mag64(v[1]) > m) m = mag64(v[1]);
      if (mag64(v[2]) > m) m = mag64(v[2]);
      s = 0;
      while ((m >> s) >= 64'sd2147483648) s++;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        v[k] = v[k] >>> s;
        sum += longint'(unsigned'(mag64(v[k]) * mag64(v[k])));
      end
      // sum of three squares can pass 2^63, kept unsigned
      len = longint'(int_sqrt(sum));
      if (len == 0) len = 1;
      for (int k = 0; k < 3; k++) begin
        q = (mag64(v[k]) * 16384 + len / 2) / len;
        if (q > 16384) q = 16384;
        q = v[k] < 0 ? -q : q;
        if (k == 0) r.fx = q[15:0];
        else if (k == 1) r.fy = q[15:0];
        else r.fz = q[15:0];
      end
    end
    return r;
  endfunction

  // driver
  int gap_in = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_views.push_back(follow_target(pending_targets.pop_front()));
        gap_in = $urandom_range(0, 3);
        s_tvalid <= 0;
      end else if (!s_tvalid) begin
        if (gap_in > 0) gap_in--;
        else if (pending_targets.size() > 0) begin
          s_tdata <= {pending_targets[0].dt, pending_targets[0].yaw,
                      pending_targets[0].tz, pending_targets[0].ty, pending_targets[0].tx};
          s_tvalid <= 1;
        end
      end
    end
  end

  // monitor
  int gap_out = 0;
  camera_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.cx = m_tdata[31:0];
        got.cy = m_tdata[63:32];
        got.cz = m_tdata[95:64];
        got.fx = m_tdata[111:96];
        got.fy = m_tdata[127:112];
        got.fz = m_tdata[143:128];
        got.degen = m_tuser;
        if (expected_views.size() == 0) begin
          $display("%0t unexpected word %h/%b", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_views.pop_front();
          if (got.cx !== want.cx) begin
            $display("%0t cam_x exp %h got %h", $time, want.cx, got.cx); errors++;
          end
          if (got.cy !== want.cy) begin
            $display("%0t cam_y exp %h got %h", $time, want.cy, got.cy); errors++;
          end
          if (got.cz !== want.cz) begin
            $display("%0t cam_z exp %h got %h", $time, want.cz, got.cz); errors++;
          end
          if (got.fx !== want.fx) begin
            $display("%0t fwd_x exp %h got %h", $time, want.fx, got.fx); errors++;
          end
          if (got.fy !== want.fy) begin
            $display("%0t fwd_y exp %h got %h", $time, want.fy, got.fy); errors++;
          end
          if (got.fz !== want.fz) begin
            $display("%0t fwd_z exp %h got %h", $time, want.fz, got.fz); errors++;
          end
          if (got.degen !== want.degen) begin
            $display("%0t degenerate exp %b got %b", $time, want.degen, got.degen);
            errors++;
          end
        end
        gap_out = $urandom_range(0, 3);
        m_tready <= (gap_out == 0);
      end else if (gap_out > 0) begin
        gap_out--;
        m_tready <= (gap_out == 0);
      end else m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > 1500000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_setting(input logic [7:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    apply_setting(idx, val);
    cfg_valid <= 0;
  endtask

  task automatic drain;
    wait (pending_targets.size() == 0 && !s_tvalid && expected_views.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'h7FFFFFFF - $urandom_range(0, 65536 * 40);
      2: return 32'h80000000 + $urandom_range(0, 65536 * 40);
      default: return $signed($urandom_range(0, 65536 * 400)) - 65536 * 200;
    endcase
  endfunction

  function automatic target_t rand_target();
    target_t it;
    int mode;
    mode = ($urandom_range(0, 9) < 7) ? 3 : $urandom_range(0, 2);
    it.tx = rand_pos(mode);
    it.ty = rand_pos(mode);
    it.tz = rand_pos(mode);
    it.yaw = 16'($urandom);
    case ($urandom_range(0, 5))
      0: it.dt = 0;
      1: it.dt = 16'hFFFF;
      default: it.dt = 16'($urandom_range(0, 4000));
    endcase
    return it;
  endfunction

  function automatic target_t make_target(logic [31:0] x, y, z, logic [15:0] yw, d);
    target_t it;
    it.tx = x; it.ty = y; it.tz = z; it.yaw = yw; it.dt = d;
    return it;
  endfunction

  logic [15:0] yaws[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                          16'h4001, 16'hBFFF, 16'h2000, 16'hFFFF};

  initial begin
    dist_q = FOLLOW_DIST_RST;
    fhgt_q = FOLLOW_HGT_RST;
    lhgt_q = LOOK_HGT_RST;
    rate_q = SMOOTH_RATE_RST;
    px = POS_X_RST;
    py = POS_Y_RST;
    pz = POS_Z_RST;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: quadrant edges, time step extremes, saturating targets
    foreach (yaws[i])
      pending_targets.push_back(make_target(32'h10000 * i, 0, 32'hFFFF0000, yaws[i], 16'd700));
    pending_targets.push_back(make_target(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                          16'h0, 16'hFFFF));
    pending_targets.push_back(make_target(32'h80000000, 32'h80000000, 32'h80000000,
                                          16'h8000, 16'hFFFF));
    pending_targets.push_back(make_target(0, 0, 0, 16'h1234, 16'h0));
    pending_targets.push_back(make_target(32'h5555AAAA, 32'hAAAA5555, 32'h0F0F0F0F,
                                          16'hFFFF, 16'h1));
    drain();

    // camera lands on the target: zero distance, equal heights, full step
    write_setting(REG_FOLLOW_DIST, 16'h0);
    write_setting(REG_FOLLOW_HGT, 16'h0100);
    write_setting(REG_LOOK_HGT, 16'h0100);
    write_setting(REG_SMOOTH_RATE, 16'hFFFF);
    pending_targets.push_back(make_target(32'h30000, 32'h40000, 32'h50000, 16'h0, 16'hFFFF));
    pending_targets.push_back(make_target(32'h30000, 32'h40000, 32'h50000, 16'h7000, 16'h100));
    drain();
    write_setting(8'hFF, 16'hFFFF);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_setting(REG_FOLLOW_DIST, 16'hFFFF);
          write_setting(REG_FOLLOW_HGT, 16'h7FFF);
          write_setting(REG_LOOK_HGT, 16'h8000);
          write_setting(REG_SMOOTH_RATE, 16'h0);
        end
        1: begin
          write_setting(REG_FOLLOW_HGT, 16'h8000);
          write_setting(REG_LOOK_HGT, 16'h7FFF);
          write_setting(REG_SMOOTH_RATE, 16'h0500);
        end
        default: begin
          write_setting(REG_FOLLOW_DIST, 16'($urandom));
          write_setting(REG_FOLLOW_HGT, 16'($urandom));
          write_setting(REG_LOOK_HGT, 16'($urandom));
          write_setting(REG_SMOOTH_RATE, 16'($urandom_range(0, 16'h2000)));
        end
      endcase
      for (int n = 0; n < 200; n++) pending_targets.push_back(rand_target());
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
hdl/ccfs_pkg.sv
hdl/chase_camera_follow_step.sv
test/tb_chase_camera_follow_step.sv
